/* hw/rtl/rss_pkg.sv */
`timescale 1ns / 1ps

package rss_pkg;

    localparam int POINTER_BYTES  = 8;
    localparam int PTR_BITS       = 8 * POINTER_BYTES;
    localparam int WINDOW_BITS    = PTR_BITS - 8;
    localparam int KIDX_BITS      = $clog2(POINTER_BYTES);

    localparam int BYTE_BITS      = 8;
    localparam int LEN_BITS       = 17;
    localparam int POS_BITS       = 17;
    localparam int OFFSET_BITS    = 16;
    localparam int SKIP_BITS      = 2;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 2;

    localparam int MAX_FUNC_BYTES = 65536;
    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_FUNC_BYTES);

    localparam logic [BYTE_BITS-1:0] OP_RET     = 8'hc3;
    localparam logic [BYTE_BITS-1:0] OP_RET_IMM = 8'hc2;
    localparam logic [SKIP_BITS-1:0] IMM_SKIP   = 2'd2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FUNCTION_BASE,
        REG_FUNCTION_LENGTH,
        REG_SCAN_BEGIN
    } cfg_reg_t;

endpackage

/* hw/rtl/rss_byte_if.sv */
`timescale 1ns / 1ps

interface rss_byte_if;
    import rss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

/* hw/rtl/rss_site_if.sv */
`timescale 1ns / 1ps

interface rss_site_if;
    import rss_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] site_offset;
    logic                   found;
    logic                   run_last;

    modport source (output valid, output site_offset, output found, output run_last,
                    input ready);
    modport sink   (input valid, input site_offset, input found, input run_last,
                    output ready);
endinterface

/* hw/rtl/return_site_scanner.sv */
`timescale 1ns / 1ps

// Scans a function's code bytes, one per transaction, for return sites. A plain ret byte
// at or past scan_begin becomes a candidate; a ret-with-immediate and its two operand
// bytes are skipped. Every 8-byte little-endian window that points into the function
// cancels the candidates it covers. A candidate is reported once seven more bytes have
// arrived; at the function's last byte all remaining candidates are reported in
// ascending offset, followed by a closing transaction with found=0, and the scanner
// re-arms for the next function. Throughput: one code byte per cycle while no result is
// waiting on a stalled port and no final burst is draining. Each byte before the last yields
// at most one result; the last byte yields up to nine results, which leave through the
// single result port one per cycle while it is ready; the next byte can be taken in the
// same cycle as the last of them leaves. A result leaves in the same cycle as the next byte
// is taken, so only output back-pressure or a final burst holds the input.
// Configuration writes take effect on the next cycle; base, length and scan start must
// be written while no function is in flight.
module return_site_scanner (
    input  logic                                  clk,
    input  logic                                  rst_n,
    rss_byte_if.sink                              code_in,
    rss_site_if.source                            site_out,
    input  logic                                  cfg_we,
    input  logic [rss_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [rss_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
    import rss_pkg::*;

    // configuration
    logic [PTR_BITS-1:0]    base_reg,   base_next;
    logic [PTR_BITS-1:0]    limit_reg,  limit_next;
    logic [LEN_BITS-1:0]    len_reg,    len_next;
    logic [OFFSET_BITS-1:0] scan_reg,   scan_next;

    // scan state
    logic [WINDOW_BITS-1:0]   window_reg, window_next;
    logic [POINTER_BYTES-1:0] mask_reg,   mask_next;
    logic [SKIP_BITS-1:0]     skip_reg,   skip_next;
    logic [POS_BITS-1:0]      pos_reg,    pos_next;

    // result burst waiting on the output
    logic [POINTER_BYTES-1:0] burst_mask_reg,  burst_mask_next;
    logic                     burst_close_reg, burst_close_next;
    logic [OFFSET_BITS-1:0]   burst_pos_reg,   burst_pos_next;

    logic                     in_accept;
    logic                     out_drain;
    logic                     is_last;
    logic                     pos_in_func;
    logic                     in_scan;
    logic                     window_hit;
    logic [PTR_BITS-1:0]      ptr_value;
    logic [POINTER_BYTES-1:0] mask_new;
    logic [LEN_BITS-1:0]      len_clamped;
    logic                     burst_any;
    logic                     burst_single;
    logic                     out_final;
    logic [KIDX_BITS-1:0]     top_k;

    // ---------------- configuration port ----------------
    always_comb
    begin
        base_next   = base_reg;
        limit_next  = limit_reg;
        len_next    = len_reg;
        scan_next   = scan_reg;
        len_clamped = cfg_wdata[LEN_BITS-1:0];
        if (len_clamped > MAX_LEN)
        begin
            len_clamped = MAX_LEN;
        end
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FUNCTION_BASE:
                begin
                    base_next  = cfg_wdata[PTR_BITS-1:0];
                    limit_next = cfg_wdata[PTR_BITS-1:0] + PTR_BITS'(len_reg);
                end
                REG_FUNCTION_LENGTH:
                begin
                    len_next   = len_clamped;
                    limit_next = base_reg + PTR_BITS'(len_clamped);
                end
                REG_SCAN_BEGIN:
                begin
                    scan_next = cfg_wdata[OFFSET_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- output burst decode ----------------
    always_comb
    begin
        top_k = '0;
        for (int k = 0; k < POINTER_BYTES; k++)
        begin
            if (burst_mask_reg[k])
            begin
                top_k = KIDX_BITS'(k);
            end
        end
    end

    assign burst_any    = |burst_mask_reg;
    assign burst_single = $onehot(burst_mask_reg);
    assign out_final    = burst_any ? (burst_single && !burst_close_reg) : burst_close_reg;

    assign site_out.valid       = burst_any || burst_close_reg;
    assign site_out.found       = burst_any;
    assign site_out.run_last    = out_final;
    assign site_out.site_offset = burst_any ? (burst_pos_reg - OFFSET_BITS'(top_k)) : '0;

    assign out_drain     = site_out.valid && site_out.ready;
    assign code_in.ready = !site_out.valid || (site_out.ready && out_final);
    assign in_accept     = code_in.valid && code_in.ready;

    // ---------------- per-byte scan ----------------
    assign is_last     = ({1'b0, pos_reg} + (POS_BITS + 1)'(1)) >= {1'b0, len_reg};
    assign pos_in_func = pos_reg < len_reg;
    assign in_scan     = (pos_reg >= POS_BITS'(scan_reg)) && pos_in_func;
    assign ptr_value   = {code_in.code_byte, window_reg};
    // the window ending at this byte must lie wholly inside the function
    assign window_hit  = (pos_reg >= POS_BITS'(POINTER_BYTES - 1)) && pos_in_func
                         && (ptr_value >= base_reg) && (ptr_value < limit_reg);

    always_comb
    begin
        mask_new  = {mask_reg[POINTER_BYTES-2:0], 1'b0};
        skip_next = skip_reg;
        if (skip_reg != '0)
        begin
            skip_next = skip_reg - SKIP_BITS'(1);
        end
        else if (in_scan)
        begin
            if (code_in.code_byte == OP_RET_IMM)
            begin
                skip_next = IMM_SKIP;
            end
            else if (code_in.code_byte == OP_RET)
            begin
                mask_new[0] = 1'b1;
            end
        end
        if (window_hit)
        begin
            mask_new = '0;
        end

        window_next      = window_reg;
        mask_next        = mask_reg;
        pos_next         = pos_reg;
        burst_mask_next  = burst_mask_reg;
        burst_close_next = burst_close_reg;
        burst_pos_next   = burst_pos_reg;

        if (in_accept)
        begin
            burst_pos_next = pos_reg[OFFSET_BITS-1:0];
            if (is_last)
            begin
                burst_mask_next  = mask_new;
                burst_close_next = 1'b1;
                window_next      = '0;
                mask_next        = '0;
                skip_next        = '0;
                pos_next         = '0;
            end
            else
            begin
                // oldest candidate has seen enough bytes to be final
                burst_mask_next  = '0;
                burst_mask_next[POINTER_BYTES-1] = mask_new[POINTER_BYTES-1];
                burst_close_next = 1'b0;
                window_next      = ptr_value[PTR_BITS-1:8];
                mask_next        = mask_new;
                mask_next[POINTER_BYTES-1] = 1'b0;
                pos_next         = pos_reg + POS_BITS'(1);
            end
        end
        else
        begin
            skip_next = skip_reg;
            if (out_drain)
            begin
                if (burst_any)
                begin
                    burst_mask_next[top_k] = 1'b0;
                end
                else
                begin
                    burst_close_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= '0;
            limit_reg       <= PTR_BITS'(1);
            len_reg         <= LEN_BITS'(1);
            scan_reg        <= '0;
            window_reg      <= '0;
            mask_reg        <= '0;
            skip_reg        <= '0;
            pos_reg         <= '0;
            burst_mask_reg  <= '0;
            burst_close_reg <= 1'b0;
        end
        else
        begin
            base_reg        <= base_next;
            limit_reg       <= limit_next;
            len_reg         <= len_next;
            scan_reg        <= scan_next;
            window_reg      <= window_next;
            mask_reg        <= mask_next;
            skip_reg        <= skip_next;
            pos_reg         <= pos_next;
            burst_mask_reg  <= burst_mask_next;
            burst_close_reg <= burst_close_next;
        end
    end

    always_ff @(posedge clk)
    begin
        burst_pos_reg <= burst_pos_next;
    end

`ifndef ASSERT_OFF
    a_rearm_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept && is_last |=> (pos_reg == '0) && (mask_reg == '0) && (skip_reg == '0))
        else $error("scan state not cleared after last byte");

    a_oldest_never_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        !mask_reg[POINTER_BYTES-1])
        else $error("final candidate left in pending mask");

    a_only_marker_closes_burst: assert property (
        @(posedge clk) disable iff (!rst_n)
        site_out.valid && !site_out.run_last |-> site_out.found)
        else $error("closing marker not last in burst");

    a_marker_offset_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        site_out.valid && !site_out.found |-> (site_out.site_offset == '0) && site_out.run_last)
        else $error("closing marker malformed");
`endif

endmodule
